/* src/ffud_pkg.sv */
// Shared types and constants for the form field URL decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ffud_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_KEY_LO     = 3'd0;
    localparam logic [2:0] REG_KEY_MID    = 3'd1;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd2;
    localparam logic [2:0] REG_KEY_TOP    = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd4;

    // Scan modes
    localparam logic [1:0] MODE_MATCH    = 2'd0;
    localparam logic [1:0] MODE_SKIP     = 2'd1;
    localparam logic [1:0] MODE_VALUE    = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    // Escape phases
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    // Characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic       found;
    } out_item_t;

    typedef struct packed {
        out_item_t [RES_SLOTS-1:0] item;
        logic [1:0]                count;
    } res_bundle_t;

    // Hex digit value: bit 4 flags a legal digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b1, 4'(ch - 8'h61) + HEX_TEN};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b1, 4'(ch - 8'h41) + HEX_TEN};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/ffud_scan.sv */
// Segment matcher and value decoder: scan state plus the per-byte result set.
// Depends on ffud_pkg.
`default_nettype none
module ffud_scan #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire ffud_pkg::in_item_t    in_item,
    input  wire logic [7:0]            key_bytes [MAX_KEY_BYTES],
    input  wire logic [5:0]            key_len,
    output ffud_pkg::res_bundle_t      res
);
    import ffud_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [5:0] KEY_MAX = 6'(MAX_KEY_BYTES);

    logic [5:0] pos_reg, pos_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [7:0] c;
    logic       last;
    logic [5:0] klen;
    logic [7:0] kchar;
    logic [4:0] nib_c, nib_h;
    logic       ended, found, amp, do_plain;
    logic [1:0] pre_n;
    logic [7:0] pre0, pre1;
    logic       pl_v;
    logic [7:0] pl_b;
    logic [1:0] n;
    out_item_t  plain_item;

    always_comb begin
        c     = in_item.in_byte;
        last  = in_item.body_last;
        klen  = (key_len > KEY_MAX) ? KEY_MAX : key_len;
        kchar = key_bytes[pos_reg[KIDX_W-1:0]];
        nib_c = hex_nibble(c);
        nib_h = hex_nibble(held_reg);

        pos_next   = pos_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        ended      = 1'b0;
        found      = 1'b0;
        amp        = 1'b0;
        do_plain   = 1'b0;
        pre_n      = 2'd0;
        pre0       = 8'd0;
        pre1       = 8'd0;
        pl_v       = 1'b0;
        pl_b       = 8'd0;

        case (mode_reg)
            MODE_MATCH: begin
                if (pos_reg < klen) begin
                    if (c == CH_AMP) begin
                        pos_next = 6'd0;
                    end else if (c == kchar) begin
                        pos_next = pos_reg + 6'd1;
                    end else begin
                        mode_next = MODE_SKIP;
                    end
                end else if (c == CH_EQ) begin
                    mode_next  = MODE_VALUE;
                    phase_next = ESC_NONE;
                    found      = last;
                end else if (c == CH_AMP) begin
                    pos_next = 6'd0;
                end else begin
                    mode_next = MODE_SKIP;
                end
                ended = last;
            end
            MODE_SKIP: begin
                if (c == CH_AMP) begin
                    pos_next  = 6'd0;
                    mode_next = MODE_MATCH;
                end
                ended = last;
            end
            MODE_VALUE: begin
                found = 1'b1;
                case (phase_reg)
                    ESC_PCT: begin
                        if (nib_c[4] && !last) begin
                            held_next  = c;
                            phase_next = ESC_DIGIT;
                        end else begin
                            pre_n      = 2'd1;
                            pre0       = CH_PCT;
                            phase_next = ESC_NONE;
                            do_plain   = 1'b1;
                        end
                    end
                    ESC_DIGIT: begin
                        phase_next = ESC_NONE;
                        if (nib_c[4] && nib_h[4]) begin
                            pre_n = 2'd1;
                            pre0  = {nib_h[3:0], nib_c[3:0]};
                        end else begin
                            pre_n    = 2'd2;
                            pre0     = CH_PCT;
                            pre1     = held_reg;
                            do_plain = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = ESC_NONE;
                        do_plain   = 1'b1;
                    end
                endcase
                if (do_plain) begin
                    if (c == CH_AMP) begin
                        amp = 1'b1;
                    end else if (c == CH_PLUS) begin
                        pl_v = 1'b1;
                        pl_b = CH_SPACE;
                    end else if (c == CH_PCT) begin
                        if (last) begin
                            pl_v = 1'b1;
                            pl_b = CH_PCT;
                        end else begin
                            phase_next = ESC_PCT;
                        end
                    end else begin
                        pl_v = 1'b1;
                        pl_b = c;
                    end
                end
                if (amp || last) begin
                    ended     = 1'b1;
                    mode_next = MODE_FINISHED;
                end
            end
            default: begin
            end
        endcase

        // End of body: return to the reset state
        if (last) begin
            pos_next   = 6'd0;
            mode_next  = MODE_MATCH;
            phase_next = ESC_NONE;
            held_next  = 8'd0;
        end
    end

    // Assemble escape prefix bytes followed by the plain byte
    always_comb begin
        plain_item = '{out_byte: pl_b, byte_valid: pl_v, done_res: 1'b0, found: found};
        res        = '0;
        n          = pre_n + {1'b0, pl_v};
        case (pre_n)
            2'd0: begin
                res.item[0] = plain_item;
            end
            2'd1: begin
                res.item[0] = '{out_byte: pre0, byte_valid: 1'b1, done_res: 1'b0, found: found};
                res.item[1] = plain_item;
            end
            default: begin
                res.item[0] = '{out_byte: pre0, byte_valid: 1'b1, done_res: 1'b0, found: found};
                res.item[1] = '{out_byte: pre1, byte_valid: 1'b1, done_res: 1'b0, found: found};
                res.item[2] = plain_item;
            end
        endcase
        // Empty end marker when the ending byte decoded to nothing
        if (ended && n == 2'd0) begin
            n = 2'd1;
        end
        for (int k = 0; k < RES_SLOTS; k++) begin
            res.item[k].done_res = ended && (2'(k) == n - 2'd1);
        end
        res.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 6'd0;
            mode_reg  <= MODE_MATCH;
            phase_reg <= ESC_NONE;
            held_reg  <= 8'd0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule
`default_nettype wire

/* src/ffud_outq.sv */
// Result register bank: holds up to three results of one byte and drains them in order.
// Depends on ffud_pkg.
`default_nettype none
module ffud_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire ffud_pkg::res_bundle_t res_in,
    output logic                       can_load,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ffud_pkg::out_item_t        m_data
);
    import ffud_pkg::*;

    out_item_t  slot_reg [RES_SLOTS];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    // Free after this cycle if empty or the last held result leaves now
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_data   = slot_reg[rd_reg];

    always_comb begin
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (load) begin
            rd_next  = 2'd0;
            cnt_next = res_in.count;
        end else if (pop) begin
            rd_next  = rd_reg + 2'd1;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 2'd0;
            cnt_reg <= 2'd0;
        end else begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < RES_SLOTS; k++) begin
                slot_reg[k] <= res_in.item[k];
            end
        end
    end

endmodule
`default_nettype wire

/* src/form_field_url_decoder.sv */
// Top level of the form field URL decoder: configuration registers, scanner, result bank.
// Depends on ffud_pkg, ffud_scan and ffud_outq.
//
// Usage:
//   s_* channel takes one body byte per transaction, with body_last on the final byte.
//   m_* channel returns results: decoded value bytes of the first segment whose key
//   matches, each carrying found; done_res marks the last result of a body. A body
//   without the key ends with one result with byte_valid 0, found 0, done_res 1.
//   cfg_* is a plain write port: cfg_index 0..3 load key characters 8 at a time,
//   index 4 loads the key length; other indexes are ignored. Write only while idle.
// Latency and throughput:
//   Each accepted byte is decoded in the cycle it is accepted, and its results
//   appear on m_* from the next cycle, one per cycle while m_ready is high. A byte with
//   no result leaves the bank free; a byte with k results (k up to 3, from an escape
//   flush) holds the bank until its last result leaves, which sets the input rate.
// Reset (aresetn low, synchronous): clear the key registers, the scan state and the
//   result bank; m_valid goes low on a clock edge with aresetn low.
// Stall: while m_ready is low the pending results hold; s_ready falls once the bank
//   cannot take the next byte's results, and input bytes wait upstream.
`default_nettype none
module form_field_url_decoder #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ffud_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ffud_pkg::out_item_t       m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [63:0]          cfg_wdata
);
    import ffud_pkg::*;

    logic [7:0]  key_reg [MAX_KEY_BYTES];
    logic [5:0]  key_len_reg;
    logic        accept;
    logic        can_load;
    res_bundle_t res;

    // Store only the key characters the comparator can reach
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                key_reg[b] <= 8'd0;
            end
            key_len_reg <= 6'd0;
        end else if (cfg_wr_en) begin
            for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                if (cfg_index == 3'(b >> 3)) begin
                    key_reg[b] <= cfg_wdata[8*(b & 7) +: 8];
                end
            end
            if (cfg_index == REG_KEY_LENGTH) begin
                key_len_reg <= cfg_wdata[5:0];
            end
        end
    end

    // Take a byte whenever the result bank will be free for its results
    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    ffud_scan #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_item   (s_data),
        .key_bytes (key_reg),
        .key_len   (key_len_reg),
        .res       (res)
    );

    ffud_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res_in   (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

/* src/ffud_checker.sv */
// Port-level checks for the form field URL decoder, bound to the top level.
// Depends on ffud_pkg and form_field_url_decoder.
`default_nettype none
module ffud_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ffud_pkg::out_item_t m_data
);
    import ffud_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // An empty result is only ever the end marker, with a zero byte
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.done_res && m_data.out_byte == 8'd0)
        else $error("empty result without done mark");

    // Decoded bytes only come from a located value
    a_byte_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_valid |-> m_data.found)
        else $error("decoded byte without found");

endmodule

bind form_field_url_decoder ffud_checker u_ffud_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
